@@ design/sil_pkg.sv @@
// Shared types and codes for the sorted identifier list.
`default_nettype none
package sil_pkg;

  localparam int ID_W = 64;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]      command;
    logic [ID_W-1:0] ident;
    logic [5:0]      position;
  } cmd_t;

  typedef struct packed {
    logic [6:0]      entry_count;
    logic            found;
    logic [ID_W-1:0] entry_value;
    logic [1:0]      status;
  } res_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic            exec;
    logic            ins;
    logic            rem;
    logic            query;
    logic            read;
    logic [ID_W-1:0] ident;
  } ctrl_t;

endpackage
`default_nettype wire

@@ design/sil_stream_if.sv @@
// Valid/ready channel carrying one item of a given payload type.
`default_nettype none
interface sil_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ design/sil_cell.sv @@
// One slot of the sorted chain: holds an entry and shifts it to or from its neighbours.
`default_nettype none
module sil_cell #(
  parameter int INDEX = 0,
  parameter int PW    = 7
) (
  input  wire logic                      clk,
  input  wire sil_pkg::ctrl_t            ctrl,
  input  wire logic [PW-1:0]             count,
  input  wire logic [PW-1:0]             pos,
  input  wire logic [sil_pkg::ID_W-1:0]  left_value,
  input  wire logic                      left_gt,
  input  wire logic [sil_pkg::ID_W-1:0]  right_value,
  output logic [sil_pkg::ID_W-1:0]       value,
  output logic                           gt,
  output logic                           leaf_found,
  output logic [sil_pkg::ID_W-1:0]       leaf_value
);

  localparam logic [PW-1:0] IDX      = PW'(INDEX);
  localparam logic [PW-1:0] IDX_NEXT = PW'(INDEX + 1);

  logic occupied;
  logic at_count;
  logic from_pos;
  logic has_right;

  assign occupied  = IDX < count;
  assign at_count  = IDX == count;
  assign from_pos  = IDX >= pos;
  assign has_right = IDX_NEXT < count;
  assign gt        = occupied && (value > ctrl.ident);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      // take the left entry if it moves up, else land the new one at its place
      if (left_gt) begin
        value <= left_value;
      end else if (gt || at_count) begin
        value <= ctrl.ident;
      end
    end else if (ctrl.rem && from_pos && has_right) begin
      value <= right_value;
    end
    if (ctrl.exec) begin
      leaf_found <= ctrl.query && occupied && (value == ctrl.ident);
      leaf_value <= (ctrl.read && occupied && (IDX == pos)) ? value : '0;
    end
  end

endmodule
`default_nettype wire

@@ design/sil_tree.sv @@
// Registered OR tree, four to one per level, gathering the cells' query and read results.
`default_nettype none
module sil_tree #(
  parameter int N = 64
) (
  input  wire logic                      clk,
  input  wire logic [N-1:0]              leaf_found,
  input  wire logic [sil_pkg::ID_W-1:0]  leaf_value [N],
  output logic                           root_found,
  output logic [sil_pkg::ID_W-1:0]       root_value
);

  localparam int L = ($clog2(N) + 1) / 2;
  localparam int P = 1 << (2 * L);

  function automatic int lvl_off(input int k);
    int o;
    o = 0;
    for (int j = 0; j < k; j++) begin
      o += P >> (2 * j);
    end
    return o;
  endfunction

  localparam int NODES = lvl_off(L + 1) - P;
  localparam int ROOT  = lvl_off(L) - P;

  logic [P-1:0]             pad_found;
  logic [sil_pkg::ID_W-1:0] pad_value [P];
  logic [NODES-1:0]         node_found;
  logic [sil_pkg::ID_W-1:0] node_value [NODES];

  for (genvar j = 0; j < P; j++) begin : g_pad
    if (j < N) begin : g_leaf
      assign pad_found[j] = leaf_found[j];
      assign pad_value[j] = leaf_value[j];
    end else begin : g_zero
      assign pad_found[j] = 1'b0;
      assign pad_value[j] = '0;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= L; k++) begin
      for (int j = 0; j < (P >> (2 * k)); j++) begin
        if (k == 1) begin
          node_found[j] <= |pad_found[4*j +: 4];
          node_value[j] <= pad_value[4*j] | pad_value[4*j+1]
                         | pad_value[4*j+2] | pad_value[4*j+3];
        end else begin
          node_found[lvl_off(k) - P + j] <=
            |node_found[lvl_off(k-1) - P + 4*j +: 4];
          node_value[lvl_off(k) - P + j] <=
              node_value[lvl_off(k-1) - P + 4*j]
            | node_value[lvl_off(k-1) - P + 4*j + 1]
            | node_value[lvl_off(k-1) - P + 4*j + 2]
            | node_value[lvl_off(k-1) - P + 4*j + 3];
        end
      end
    end
  end

  assign root_found = node_found[ROOT];
  assign root_value = node_value[ROOT];

endmodule
`default_nettype wire

@@ design/sorted_id_list_top.sv @@
// Sorted identifier list: sequencer, chain of slots and result gathering tree.
//
// Commands arrive on cmd (insert, remove at position, query, read at position)
// and exactly one result per command leaves on res, carrying the count after
// the command, the found flag, the read value and a status code.
// The list lives in a row of CAPACITY slots; an insert or remove shifts every
// affected slot into its neighbour together, found by a compare in each slot.
// Query and read results are gathered by a registered four-to-one OR tree of
// L = ceil(log4(CAPACITY)) levels (3 at CAPACITY 64).
// A command is registered on acceptance, executed in the slots, then gathered by the tree into the result.
// One command is in flight at a time; a finished result waits in the output
// register while the next command is accepted and worked on, and a stalled
// receiver holds the block only once a second result is ready.
// Reset empties the list (count zero) and drops any pending result; it needs
// no clearing pass over the slots.
`default_nettype none
module sorted_id_list_top #(
  parameter int CAPACITY = 64
) (
  input  wire logic    clk,
  input  wire logic    rst,
  sil_stream_if.sink   cmd,
  sil_stream_if.source res
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 6) ? CW : 6;
  localparam int TL = ($clog2(CAPACITY) + 1) / 2;
  localparam int KW = $clog2(TL + 1);

  typedef enum logic [1:0] {IDLE, EXEC, REDUCE} state_t;

  state_t          state;
  logic [KW-1:0]   cnt;
  logic [CW-1:0]   count;
  sil_pkg::cmd_t   cmd_q;
  logic [1:0]      status_q;
  logic            res_valid;
  sil_pkg::res_t   res_payload;

  logic [PW-1:0]   pos_ext;
  logic [PW-1:0]   count_ext;
  logic            full;
  logic            range_bad;
  logic            res_load;
  sil_pkg::ctrl_t  ctrl;

  logic [sil_pkg::ID_W-1:0] values [CAPACITY];
  logic [CAPACITY-1:0]      gts;
  logic [CAPACITY-1:0]      leaf_found;
  logic [sil_pkg::ID_W-1:0] leaf_value [CAPACITY];
  logic                     root_found;
  logic [sil_pkg::ID_W-1:0] root_value;

  assign pos_ext   = PW'(cmd_q.position);
  assign count_ext = PW'(count);
  assign full      = count == CW'(CAPACITY);
  assign range_bad = pos_ext >= count_ext;
  assign res_load  = (state == REDUCE) && (cnt == KW'(TL)) && (!res_valid || res.ready);

  always_comb begin
    ctrl.exec  = state == EXEC;
    ctrl.ins   = ctrl.exec && (cmd_q.command == sil_pkg::CMD_INSERT) && !full;
    ctrl.rem   = ctrl.exec && (cmd_q.command == sil_pkg::CMD_REMOVE) && !range_bad;
    ctrl.query = cmd_q.command == sil_pkg::CMD_QUERY;
    ctrl.read  = cmd_q.command == sil_pkg::CMD_READ;
    ctrl.ident = cmd_q.ident;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [sil_pkg::ID_W-1:0] lv;
    logic                     lg;
    logic [sil_pkg::ID_W-1:0] rv;
    if (i == 0) begin : g_first
      assign lv = '0;
      assign lg = 1'b0;
    end else begin : g_inner
      assign lv = values[i-1];
      assign lg = gts[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rv = '0;
    end else begin : g_rest
      assign rv = values[i+1];
    end
    sil_cell #(
      .INDEX (i),
      .PW    (PW)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (count_ext),
      .pos         (pos_ext),
      .left_value  (lv),
      .left_gt     (lg),
      .right_value (rv),
      .value       (values[i]),
      .gt          (gts[i]),
      .leaf_found  (leaf_found[i]),
      .leaf_value  (leaf_value[i])
    );
  end

  sil_tree #(
    .N (CAPACITY)
  ) u_tree (
    .clk        (clk),
    .leaf_found (leaf_found),
    .leaf_value (leaf_value),
    .root_found (root_found),
    .root_value (root_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      cnt       <= '0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (cmd.valid) begin
            cmd_q <= cmd.payload;
            state <= EXEC;
          end
        end
        EXEC: begin
          case (cmd_q.command)
            sil_pkg::CMD_INSERT: begin
              if (full) begin
                status_q <= sil_pkg::ST_FULL;
              end else begin
                status_q <= sil_pkg::ST_OK;
                count    <= count + CW'(1);
              end
            end
            sil_pkg::CMD_REMOVE: begin
              if (range_bad) begin
                status_q <= sil_pkg::ST_RANGE;
              end else begin
                status_q <= sil_pkg::ST_OK;
                count    <= count - CW'(1);
              end
            end
            sil_pkg::CMD_READ: begin
              status_q <= range_bad ? sil_pkg::ST_RANGE : sil_pkg::ST_OK;
            end
            default: begin
              status_q <= sil_pkg::ST_OK;
            end
          endcase
          cnt   <= '0;
          state <= REDUCE;
        end
        REDUCE: begin
          if (cnt == KW'(TL)) begin
            // hold until the output register is free
            if (res_load) begin
              res_payload.entry_count <= 7'(count);
              res_payload.found       <= root_found;
              res_payload.entry_value <= root_value;
              res_payload.status      <= status_q;
              state                   <= IDLE;
            end
          end else begin
            cnt <= cnt + KW'(1);
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign cmd.ready   = state == IDLE;
  assign res.valid   = res_valid;
  assign res.payload = res_payload;

endmodule
`default_nettype wire
